// ===== rtl/core/command_replay_guard_defines.svh =====
// Assertion macros shared by the command replay guard RTL.
// Depends on nothing; the asserting module supplies the clock and reset signals.
`ifndef COMMAND_REPLAY_GUARD_DEFINES_SVH
`define COMMAND_REPLAY_GUARD_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("command replay guard check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("command replay guard check failed");

`endif

// ===== rtl/core/crg_pkg.sv =====
// Shared constants, codes and types of the command replay guard.
// Depends on nothing; the modules of the block refer to it by scoped names.
package crg_pkg;

   localparam int HIST_DEPTH    = 8;
   localparam int NONCE_DEPTH   = 8;
   localparam int PAYLOAD_BYTES = 8;

   localparam logic [63:0] PAYLOAD_MASK = {64{1'b1}} >> (64 - 8 * PAYLOAD_BYTES);
   localparam logic [7:0]  SEQ_HALF     = 8'd128;

   localparam logic [1:0] OP_CHECK = 2'd0;
   localparam logic [1:0] OP_EVAL  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   localparam logic [1:0] DEC_ACCEPT           = 2'd0;
   localparam logic [1:0] DEC_DUPLICATE        = 2'd1;
   localparam logic [1:0] DEC_REPLAY           = 2'd2;
   localparam logic [1:0] DEC_SESSION_REQUIRED = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  seq;
      logic [63:0] pay;
   } hist_entry_type;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic        dup;
      logic [7:0]  seq;
      logic [63:0] pay;
   } hist_query_type;

   typedef struct packed {
      logic        shift;
      logic        clear;
      hist_entry_type entry;
   } hist_ctl_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] nonce;
   } nonce_entry_type;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic [31:0] nonce;
   } nonce_query_type;

   typedef struct packed {
      logic            shift;
      nonce_entry_type entry;
   } nonce_ctl_type;

endpackage

// ===== rtl/core/crg_hist_cell.sv =====
// One cell of the frame history chain: holds one recorded frame and matches the passing request.
// Depends on crg_pkg.
module crg_hist_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  crg_pkg::hist_query_type query_i,
   output crg_pkg::hist_query_type query_o,
   input  logic                   shift,
   input  crg_pkg::hist_entry_type left_entry,
   output crg_pkg::hist_entry_type entry_o
);

   crg_pkg::hist_entry_type entry_ff, entry_in;
   crg_pkg::hist_query_type query_ff, query_in;
   logic match;

   assign match = entry_ff.valid && (entry_ff.seq == query_i.seq);

   always_comb begin
      query_in     = query_i;
      query_in.hit = query_i.hit | match;
      query_in.dup = query_i.dup | (match && (entry_ff.pay == query_i.pay));
      entry_in     = shift ? left_entry : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         query_ff <= '0;
      end else begin
         entry_ff <= entry_in;
         query_ff <= query_in;
      end
   end

   assign query_o = query_ff;
   assign entry_o = entry_ff;

endmodule

// ===== rtl/core/crg_nonce_cell.sv =====
// One cell of the used-nonce chain: holds one nonce and matches the passing request.
// Depends on crg_pkg.
module crg_nonce_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  crg_pkg::nonce_query_type query_i,
   output crg_pkg::nonce_query_type query_o,
   input  logic                    shift,
   input  crg_pkg::nonce_entry_type left_entry,
   output crg_pkg::nonce_entry_type entry_o
);

   crg_pkg::nonce_entry_type entry_ff, entry_in;
   crg_pkg::nonce_query_type query_ff, query_in;

   always_comb begin
      query_in     = query_i;
      query_in.hit = query_i.hit | (entry_ff.valid && (entry_ff.nonce == query_i.nonce));
      entry_in     = shift ? left_entry : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         query_ff <= '0;
      end else begin
         entry_ff <= entry_in;
         query_ff <= query_in;
      end
   end

   assign query_o = query_ff;
   assign entry_o = entry_ff;

endmodule

// ===== rtl/core/crg_ctrl.sv =====
// Sequencer and session state of the command replay guard: launches requests into the
// cell chains, forms the decision and commits updates. Depends on crg_pkg and the defines header.
`include "command_replay_guard_defines.svh"

module crg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_operation,
   input  logic [31:0]              req_nonce,
   input  logic [7:0]               req_tag,
   input  logic [7:0]               req_sequence_req,
   input  logic [63:0]              req_payload,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_decision,
   output crg_pkg::hist_query_type  hist_head,
   input  crg_pkg::hist_query_type  hist_tail,
   output crg_pkg::hist_ctl_type    hist_ctl,
   output crg_pkg::nonce_query_type nonce_head,
   input  crg_pkg::nonce_query_type nonce_tail,
   output crg_pkg::nonce_ctl_type   nonce_ctl
);

   crg_pkg::state_type state_ff, state_in;

   logic [1:0]  op_ff, op_in;
   logic [31:0] nonce_ff, nonce_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  seq_ff, seq_in;
   logic [63:0] pay_ff, pay_in;

   logic hist_done_ff, hist_done_in;
   logic hist_hit_ff, hist_hit_in;
   logic hist_dup_ff, hist_dup_in;
   logic nonce_done_ff, nonce_done_in;
   logic nonce_hit_ff, nonce_hit_in;

   logic        session_active_ff, session_active_in;
   logic [31:0] active_nonce_ff, active_nonce_in;
   logic [7:0]  active_tag_ff, active_tag_in;
   logic [7:0]  last_seq_ff, last_seq_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_decision_ff, rsp_decision_in;

   logic       accept;
   logic       deciding;
   logic [7:0] seq_gap;
   logic [1:0] judge_dec;
   logic [1:0] dec;
   logic       record;
   logic       new_session;

   assign accept   = start && (state_ff == crg_pkg::ST_IDLE);
   assign busy     = (state_ff != crg_pkg::ST_IDLE);
   assign deciding = (state_ff == crg_pkg::ST_DECIDE);

   always_comb begin
      hist_head       = '0;
      hist_head.valid = accept;
      hist_head.seq   = req_sequence_req;
      hist_head.pay   = req_payload & crg_pkg::PAYLOAD_MASK;
      nonce_head       = '0;
      nonce_head.valid = accept;
      nonce_head.nonce = req_nonce;
   end

   // Sequence test shared by check, evaluate and a restart of the active session.
   always_comb begin
      seq_gap = seq_ff - last_seq_ff;
      if (hist_hit_ff) begin
         judge_dec = hist_dup_ff ? crg_pkg::DEC_DUPLICATE : crg_pkg::DEC_REPLAY;
      end else if ((seq_gap == 8'd0) || (seq_gap >= crg_pkg::SEQ_HALF)) begin
         judge_dec = crg_pkg::DEC_REPLAY;
      end else begin
         judge_dec = crg_pkg::DEC_ACCEPT;
      end
   end

   always_comb begin
      dec         = crg_pkg::DEC_REPLAY;
      record      = 1'b0;
      new_session = 1'b0;
      unique case (op_ff)
         crg_pkg::OP_CHECK, crg_pkg::OP_EVAL: begin
            if (!session_active_ff) begin
               dec = crg_pkg::DEC_SESSION_REQUIRED;
            end else if (active_tag_ff != tag_ff) begin
               dec = crg_pkg::DEC_REPLAY;
            end else begin
               dec    = judge_dec;
               record = (op_ff == crg_pkg::OP_CHECK) && (judge_dec == crg_pkg::DEC_ACCEPT);
            end
         end
         crg_pkg::OP_START: begin
            priority if (nonce_ff == 32'd0) begin
               dec = crg_pkg::DEC_REPLAY;
            end else if (session_active_ff && (active_nonce_ff == nonce_ff)
                         && (active_tag_ff == tag_ff)) begin
               dec    = judge_dec;
               record = (judge_dec == crg_pkg::DEC_ACCEPT);
            end else if (nonce_hit_ff) begin
               dec = crg_pkg::DEC_REPLAY;
            end else begin
               dec         = crg_pkg::DEC_ACCEPT;
               record      = 1'b1;
               new_session = 1'b1;
            end
         end
         default: begin
            dec = crg_pkg::DEC_REPLAY;
         end
      endcase
   end

   always_comb begin
      hist_ctl.shift       = deciding && record;
      hist_ctl.clear       = deciding && new_session;
      hist_ctl.entry.valid = 1'b1;
      hist_ctl.entry.seq   = seq_ff;
      hist_ctl.entry.pay   = pay_ff;
      nonce_ctl.shift       = deciding && new_session;
      nonce_ctl.entry.valid = 1'b1;
      nonce_ctl.entry.nonce = nonce_ff;
   end

   always_comb begin
      state_in          = state_ff;
      op_in             = op_ff;
      nonce_in          = nonce_ff;
      tag_in            = tag_ff;
      seq_in            = seq_ff;
      pay_in            = pay_ff;
      hist_done_in      = hist_done_ff | hist_tail.valid;
      hist_hit_in       = hist_tail.valid ? hist_tail.hit : hist_hit_ff;
      hist_dup_in       = hist_tail.valid ? hist_tail.dup : hist_dup_ff;
      nonce_done_in     = nonce_done_ff | nonce_tail.valid;
      nonce_hit_in      = nonce_tail.valid ? nonce_tail.hit : nonce_hit_ff;
      session_active_in = session_active_ff;
      active_nonce_in   = active_nonce_ff;
      active_tag_in     = active_tag_ff;
      last_seq_in       = last_seq_ff;
      rsp_valid_in      = 1'b0;
      rsp_decision_in   = rsp_decision_ff;
      unique case (state_ff)
         crg_pkg::ST_IDLE: begin
            if (accept) begin
               state_in      = crg_pkg::ST_WALK;
               op_in         = req_operation;
               nonce_in      = req_nonce;
               tag_in        = req_tag;
               seq_in        = req_sequence_req;
               pay_in        = req_payload & crg_pkg::PAYLOAD_MASK;
               hist_done_in  = 1'b0;
               nonce_done_in = 1'b0;
            end
         end
         crg_pkg::ST_WALK: begin
            if (hist_done_in && nonce_done_in) begin
               state_in = crg_pkg::ST_DECIDE;
            end
         end
         crg_pkg::ST_DECIDE: begin
            state_in        = crg_pkg::ST_IDLE;
            rsp_valid_in    = 1'b1;
            rsp_decision_in = dec;
            if (record) begin
               last_seq_in = seq_ff;
            end
            if (new_session) begin
               session_active_in = 1'b1;
               active_nonce_in   = nonce_ff;
               active_tag_in     = tag_ff;
            end
         end
         default: begin
            state_in = crg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= crg_pkg::ST_IDLE;
         hist_done_ff      <= 1'b0;
         hist_hit_ff       <= 1'b0;
         hist_dup_ff       <= 1'b0;
         nonce_done_ff     <= 1'b0;
         nonce_hit_ff      <= 1'b0;
         session_active_ff <= 1'b0;
         active_nonce_ff   <= 32'd0;
         active_tag_ff     <= 8'd0;
         last_seq_ff       <= 8'd0;
         rsp_valid_ff      <= 1'b0;
         rsp_decision_ff   <= crg_pkg::DEC_ACCEPT;
      end else begin
         state_ff          <= state_in;
         hist_done_ff      <= hist_done_in;
         hist_hit_ff       <= hist_hit_in;
         hist_dup_ff       <= hist_dup_in;
         nonce_done_ff     <= nonce_done_in;
         nonce_hit_ff      <= nonce_hit_in;
         session_active_ff <= session_active_in;
         active_nonce_ff   <= active_nonce_in;
         active_tag_ff     <= active_tag_in;
         last_seq_ff       <= last_seq_in;
         rsp_valid_ff      <= rsp_valid_in;
         rsp_decision_ff   <= rsp_decision_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      nonce_ff <= nonce_in;
      tag_ff   <= tag_in;
      seq_ff   <= seq_in;
      pay_ff   <= pay_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_decision = rsp_decision_ff;

   `CRG_ASSERT_NEXT(a_decide_responds, state_ff == crg_pkg::ST_DECIDE, rsp_valid_ff)
   `CRG_ASSERT_NOW(a_hist_tail_in_walk, hist_tail.valid, state_ff == crg_pkg::ST_WALK)
   `CRG_ASSERT_NOW(a_nonce_tail_in_walk, nonce_tail.valid, state_ff == crg_pkg::ST_WALK)
   `CRG_ASSERT_NOW(a_clear_records, hist_ctl.clear, hist_ctl.shift && nonce_ctl.shift)
   `CRG_ASSERT_NEXT(a_new_session_active, nonce_ctl.shift, session_active_ff)

endmodule

// ===== rtl/core/command_replay_guard.sv =====
// A request accepted at a clock edge walks both cell chains, then the sequencer passes
// through its decide state and gives its one-cycle rsp_valid strobe; busy falls in that same cycle.
// A new request is taken only once the last one is done, as start is ignored while busy;
// the wait is set by the request walking one cell per cycle through the longer cell chain.
// Reset is synchronous and active high; it ends any session and empties both histories.
// The receiver cannot stall: each decision is shown for exactly one cycle.
//
// Depends on crg_pkg, crg_ctrl, crg_hist_cell and crg_nonce_cell.
module command_replay_guard (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_nonce,
   input  logic [7:0]  req_tag,
   input  logic [7:0]  req_sequence_req,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   output logic [1:0]  rsp_decision
);

   // Each request enters the head of both chains and moves one cell per cycle.
   // Every cell compares it against the entry it holds and ORs in its match, so
   // the tail shows whether any stored frame or nonce matched. Stored values are
   // unique within each chain, so at most one cell can match a given request.
   crg_pkg::hist_query_type  hist_query [crg_pkg::HIST_DEPTH + 1];
   crg_pkg::hist_entry_type  hist_entry [crg_pkg::HIST_DEPTH];
   crg_pkg::hist_entry_type  hist_left  [crg_pkg::HIST_DEPTH];
   crg_pkg::nonce_query_type nonce_query [crg_pkg::NONCE_DEPTH + 1];
   crg_pkg::nonce_entry_type nonce_entry [crg_pkg::NONCE_DEPTH];
   crg_pkg::nonce_entry_type nonce_left  [crg_pkg::NONCE_DEPTH];
   crg_pkg::hist_ctl_type    hist_ctl;
   crg_pkg::nonce_ctl_type   nonce_ctl;

   // The sequencer holds the session state, launches requests, waits for both
   // chain tails and then commits the decision and any history updates.
   crg_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_nonce         (req_nonce),
      .req_tag           (req_tag),
      .req_sequence_req  (req_sequence_req),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_decision      (rsp_decision),
      .hist_head         (hist_query[0]),
      .hist_tail         (hist_query[crg_pkg::HIST_DEPTH]),
      .hist_ctl          (hist_ctl),
      .nonce_head        (nonce_query[0]),
      .nonce_tail        (nonce_query[crg_pkg::NONCE_DEPTH]),
      .nonce_ctl         (nonce_ctl)
   );

   // Recording shifts the new frame into the first cell and pushes the oldest
   // frame off the end, which keeps the same set of frames as a ring buffer.
   // Opening a session also invalidates everything behind the first cell.
   for (genvar k = 0; k < crg_pkg::HIST_DEPTH; k++) begin : g_hist
      if (k == 0) begin : g_first
         assign hist_left[k] = hist_ctl.entry;
      end else begin : g_rest
         assign hist_left[k] = {hist_entry[k - 1].valid && !hist_ctl.clear,
                                hist_entry[k - 1].seq, hist_entry[k - 1].pay};
      end

      crg_hist_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .query_i    (hist_query[k]),
         .query_o    (hist_query[k + 1]),
         .shift      (hist_ctl.shift),
         .left_entry (hist_left[k]),
         .entry_o    (hist_entry[k])
      );
   end

   // Used nonces are kept the same way; the oldest is forgotten first.
   for (genvar k = 0; k < crg_pkg::NONCE_DEPTH; k++) begin : g_nonce
      if (k == 0) begin : g_first
         assign nonce_left[k] = nonce_ctl.entry;
      end else begin : g_rest
         assign nonce_left[k] = nonce_entry[k - 1];
      end

      crg_nonce_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .query_i    (nonce_query[k]),
         .query_o    (nonce_query[k + 1]),
         .shift      (nonce_ctl.shift),
         .left_entry (nonce_left[k]),
         .entry_o    (nonce_entry[k])
      );
   end

endmodule
